@@ src/dtoi_pkg.sv @@
// shared constants for the decimal text to int128 converter
package dtoi_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned MagW    = 128;
  localparam int unsigned ProdW   = MagW + 4;
  localparam int unsigned CountW  = 6;
  localparam int unsigned DigitW  = 4;

  localparam logic [CharW-1:0]  CharZero  = 8'h30;
  localparam logic [CharW-1:0]  CharNine  = 8'h39;
  localparam logic [CharW-1:0]  CharMinus = 8'h2d;
  localparam logic [CharW-1:0]  CharPlus  = 8'h2b;

  localparam logic [CountW-1:0] MaxDigits = 6'd39;
  localparam logic [CountW-1:0] CountMax  = 6'd63;

  // 2^127, the largest magnitude that still fits when negative
  localparam logic [MagW-1:0]   MagTop    = {1'b1, {(MagW-1){1'b0}}};

endpackage

@@ src/decimal_text_to_int128.sv @@
// ascii decimal text to signed 128-bit integer converter, streaming top level
//
// takes one ascii character per slave beat (tdata), with tlast marking an end
// beat that carries no character. a leading '+' or '-' is allowed once, every
// other character must be '0'..'9'. each end beat gives one master beat:
// tuser is the ok flag and tdata the two's-complement value (zero when not
// ok). the string fails when empty, sign only, over 39 digits, holding a bad
// character, or out of range (above 2^127-1, or above 2^127 when negative). state
// clears after every end beat. one beat per cycle is taken sustained: a
// character moves from the input register through one shift-add of the
// 128-bit magnitude (times ten plus digit) into the accumulator, an end beat
// through one 128-bit negate into the output register. the input stalls only
// when an end beat finds the output register full and not being drained.
module decimal_text_to_int128
  import dtoi_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [CharW-1:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic              s_axis_tlast_i,   // end_mark
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [MagW-1:0]   m_axis_tdata_o,   // [63:0] value_low, [127:64] value_high
  output logic              m_axis_tuser_o    // ok
);

  // input register
  logic              in_valid_q, in_valid_d;
  logic [CharW-1:0]  in_char_q;
  logic              in_last_q;

  // accumulator state
  logic [MagW-1:0]   mag_q, mag_d;
  logic              too_big_q, too_big_d;
  logic              is_minus_q, is_minus_d;
  logic              sign_given_q, sign_given_d;
  logic [CountW-1:0] chars_seen_q, chars_seen_d;
  logic              bad_char_q, bad_char_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_ok_q, out_ok_d;
  logic [MagW-1:0]   out_value_q, out_value_d;

  logic              advance;
  logic              in_take;
  logic              is_digit;
  logic              is_sign;
  logic              at_start;
  logic [DigitW-1:0] digit;
  logic [ProdW-1:0]  prod;
  logic              prod_big;
  logic              ok;

  // the held beat moves on unless it is an end beat blocked by a full output
  assign advance = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take = s_axis_tvalid_i && s_axis_tready_o;

  assign in_valid_d = in_take || (in_valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // character classes
  assign is_digit = (in_char_q >= CharZero) && (in_char_q <= CharNine);
  assign is_sign  = (in_char_q == CharMinus) || (in_char_q == CharPlus);
  assign at_start = (chars_seen_q == '0) && !sign_given_q && !bad_char_q;
  assign digit    = DigitW'(in_char_q - CharZero);

  // times ten plus digit as (m << 3) + (m << 1) + d, four spare bits catch carry
  assign prod = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + ProdW'(digit);
  assign prod_big = (prod[ProdW-1:MagW] != '0) ||
                    (prod[MagW-1] && (prod[MagW-2:0] != '0));

  // result of an end beat
  assign ok = !bad_char_q && (chars_seen_q != '0) && (chars_seen_q <= MaxDigits) &&
              !too_big_q && !(!is_minus_q && (mag_q == MagTop));

  always_comb begin
    mag_d        = mag_q;
    too_big_d    = too_big_q;
    is_minus_d   = is_minus_q;
    sign_given_d = sign_given_q;
    chars_seen_d = chars_seen_q;
    bad_char_d   = bad_char_q;
    if (advance) begin
      if (in_last_q) begin
        // end beat: back to the cleared state
        mag_d        = '0;
        too_big_d    = 1'b0;
        is_minus_d   = 1'b0;
        sign_given_d = 1'b0;
        chars_seen_d = '0;
        bad_char_d   = 1'b0;
      end else if (is_digit) begin
        mag_d     = prod[MagW-1:0];
        too_big_d = too_big_q || prod_big;
        if (chars_seen_q != CountMax) begin
          chars_seen_d = chars_seen_q + 1'b1;
        end
      end else if (at_start && is_sign) begin
        sign_given_d = 1'b1;
        is_minus_d   = (in_char_q == CharMinus);
      end else begin
        bad_char_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q        <= '0;
      too_big_q    <= 1'b0;
      is_minus_q   <= 1'b0;
      sign_given_q <= 1'b0;
      chars_seen_q <= '0;
      bad_char_q   <= 1'b0;
    end else begin
      mag_q        <= mag_d;
      too_big_q    <= too_big_d;
      is_minus_q   <= is_minus_d;
      sign_given_q <= sign_given_d;
      chars_seen_q <= chars_seen_d;
      bad_char_q   <= bad_char_d;
    end
  end

  // output register, loaded by an end beat, drained by the master handshake
  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_ok_d    = out_ok_q;
    out_value_d = out_value_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
      out_ok_d    = ok;
      if (!ok) begin
        out_value_d = '0;
      end else if (is_minus_q) begin
        out_value_d = ~mag_q + 1'b1;
      end else begin
        out_value_d = mag_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_ok_q    <= out_ok_d;
    out_value_q <= out_value_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tdata_o  = out_value_q;

endmodule

@@ src/dtoi_checker.sv @@
// port-level checker for the decimal text to int128 converter, with its bind
module dtoi_checker
  import dtoi_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic [CharW-1:0] s_axis_tdata_i,
  input logic             s_axis_tlast_i,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [MagW-1:0]  m_axis_tdata_o,
  input logic             m_axis_tuser_o
);

  // a stalled result beat holds its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // a failed conversion carries a zero value
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("failed result with nonzero value");

  // no result is shown while reset is held
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // only an end beat can create a new result beat
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) && !(s_axis_tvalid_i && s_axis_tready_o) ##1
      (!m_axis_tvalid_o || m_axis_tready_i) && !(s_axis_tvalid_i && s_axis_tready_o)
      |=> !m_axis_tvalid_o)
    else $error("result beat without a pending end beat");

endmodule

bind decimal_text_to_int128 dtoi_checker u_dtoi_checker (.*);
